// ===== rtl/tgpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch gesture point generator package
// Shared types, register map and constants for the gesture point generator.
// ----------------------------------------------------------------------------
package tgpg_pkg;

  localparam int unsigned MaxFingersDef = 2;
  localparam logic [7:0]  TouchPressure = 8'd42;
  localparam int unsigned QuotBits      = 16;
  localparam int unsigned ProdBits      = 48;
  localparam int unsigned DivStages     = QuotBits / 2;
  localparam int unsigned AddrBits      = 5;

  typedef enum logic [1:0] {
    EV_DOWN = 2'd0,
    EV_MOVE = 2'd1,
    EV_UP   = 2'd2
  } touch_ev_e;

  typedef enum logic [2:0] {
    REG_F0_START = 3'd0,
    REG_F0_END   = 3'd1,
    REG_F1_START = 3'd2,
    REG_F1_END   = 3'd3,
    REG_PRESS    = 3'd4,
    REG_MOVE     = 3'd5,
    REG_HOLD     = 3'd6,
    REG_COUNT    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [31:0] start_ms;
  } in_req_t;

  typedef struct packed {
    logic               finger_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    touch_ev_e          touch_event;
    logic [7:0]         pressure;
    logic               position_valid;
    logic               gesture_done;
    logic               last;
  } out_req_t;

  // Payload that travels down the pipeline for one finger.
  typedef struct packed {
    logic                  fidx;
    logic                  is_last;
    logic [31:0]           etime;
    logic                  lt_press;
    logic                  lt_move;
    touch_ev_e             ev;
    logic signed [15:0]    sx;
    logic signed [15:0]    sy;
    logic signed [15:0]    ex;
    logic signed [15:0]    ey;
    logic                  negx;
    logic                  negy;
    logic [ProdBits-1:0]   remx;
    logic [ProdBits-1:0]   remy;
    logic [QuotBits-1:0]   qx;
    logic [QuotBits-1:0]   qy;
  } pipe_t;

endpackage

// ===== rtl/tgpg_div_step.sv =====
// ----------------------------------------------------------------------------
// Gesture point divider step
// Two restoring division steps for both axes of one pipeline stage.
// ----------------------------------------------------------------------------
module tgpg_div_step #(
  parameter int unsigned STEP = 0
) (
  input  tgpg_pkg::pipe_t d_i,
  input  logic [31:0]     den_i,
  output tgpg_pkg::pipe_t d_o
);

  localparam int unsigned KHi = tgpg_pkg::QuotBits - 1 - 2 * STEP;

  always_comb begin
    logic [tgpg_pkg::ProdBits-1:0] sh;
    d_o = d_i;
    for (int i = 0; i < 2; i++) begin
      sh = {{(tgpg_pkg::ProdBits-32){1'b0}}, den_i} << (KHi - i);
      if (d_o.remx >= sh) begin
        d_o.remx = d_o.remx - sh;
        d_o.qx[KHi - i] = 1'b1;
      end
      if (d_o.remy >= sh) begin
        d_o.remy = d_o.remy - sh;
        d_o.qy[KHi - i] = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/touch_gesture_point_generator.sv =====
// ----------------------------------------------------------------------------
// Touch gesture point generator
// Turns a time sample into one touch point per finger of a gesture.
// ----------------------------------------------------------------------------
// Each accepted request (current and start tick) yields one result per
// configured finger, finger 0 first, with last set on the final one. The
// block accepts a request every cycle while the output does not stall when
// one finger is configured; with two fingers it takes the next request only
// once finger 1 has left the issue stage, since one finger slot enters the
// pipeline per cycle. Finger 1 follows directly behind finger 0. On its way
// the request passes thirteen registers: an issue stage, three stages of
// phase compare and multiply, eight stages of a pipelined restoring divider
// (two quotient bits per stage) that interpolates the move phase, and the
// result register. Stall on the output freezes the whole pipeline without
// losing anything. All fingers share the phase lengths, so a finger is up
// exactly when the gesture is done. The user must write configuration
// through the APB port only while the block is idle; the block itself does
// not enforce this. Reads return the stored values.
module touch_gesture_point_generator #(
  parameter int unsigned MAX_FINGERS = tgpg_pkg::MaxFingersDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tgpg_pkg::in_req_t               in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tgpg_pkg::out_req_t              out_req_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tgpg_pkg::AddrBits-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int unsigned NDiv = tgpg_pkg::DivStages;

  // Configuration registers.
  logic [31:0] f0s_q, f0e_q, f1s_q, f1e_q, press_q, move_q, hold_q;
  logic [1:0]  count_q;
  tgpg_pkg::reg_idx_e widx;

  assign pready = 1'b1;
  assign widx   = tgpg_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0s_q   <= '0;
      f0e_q   <= '0;
      f1s_q   <= '0;
      f1e_q   <= '0;
      press_q <= 32'd50;
      move_q  <= '0;
      hold_q  <= 32'd5;
      count_q <= 2'd1;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        tgpg_pkg::REG_F0_START: f0s_q   <= pwdata;
        tgpg_pkg::REG_F0_END:   f0e_q   <= pwdata;
        tgpg_pkg::REG_F1_START: f1s_q   <= pwdata;
        tgpg_pkg::REG_F1_END:   f1e_q   <= pwdata;
        tgpg_pkg::REG_PRESS:    press_q <= pwdata;
        tgpg_pkg::REG_MOVE:     move_q  <= pwdata;
        tgpg_pkg::REG_HOLD:     hold_q  <= pwdata;
        tgpg_pkg::REG_COUNT:    count_q <= pwdata[1:0];
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      tgpg_pkg::REG_F0_START: prdata = f0s_q;
      tgpg_pkg::REG_F0_END:   prdata = f0e_q;
      tgpg_pkg::REG_F1_START: prdata = f1s_q;
      tgpg_pkg::REG_F1_END:   prdata = f1e_q;
      tgpg_pkg::REG_PRESS:    prdata = press_q;
      tgpg_pkg::REG_MOVE:     prdata = move_q;
      tgpg_pkg::REG_HOLD:     prdata = hold_q;
      tgpg_pkg::REG_COUNT:    prdata = {30'd0, count_q};
    endcase
  end

  // The whole pipeline moves whenever the result register can take data.
  logic adv;
  logic out_valid_q;
  tgpg_pkg::out_req_t out_q;
  assign adv = !out_valid_q || !out_stall_i;

  // Issue stage: holds the request and hands out one finger slot a cycle while the pipeline advances.
  logic        s0_valid_q, s0_two_q, s0_fidx_q;
  logic [31:0] s0_time_q;
  logic        two_fingers, last_slot, accept;

  assign two_fingers = (MAX_FINGERS > 1) && count_q[1];
  assign last_slot   = !(s0_two_q && !s0_fidx_q);
  assign in_stall_o  = s0_valid_q && !(adv && last_slot);
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s0_fidx_q  <= 1'b0;
    end else if (accept) begin
      s0_valid_q <= 1'b1;
      s0_fidx_q  <= 1'b0;
    end else if (adv && s0_valid_q) begin
      if (last_slot) begin
        s0_valid_q <= 1'b0;
      end else begin
        s0_fidx_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_time_q <= in_req_i.now_ms - in_req_i.start_ms;
      s0_two_q  <= two_fingers;
    end
  end

  // Stage 1: pick the finger's points and compare against the press time.
  tgpg_pkg::pipe_t s1_d, s1_q, s2_d, s2_q, s3_d, s3_q;
  logic s1_valid_q, s2_valid_q, s3_valid_q;

  always_comb begin
    logic [31:0] st, en;
    st = s0_fidx_q ? f1s_q : f0s_q;
    en = s0_fidx_q ? f1e_q : f0e_q;
    s1_d          = '0;
    s1_d.fidx     = s0_fidx_q;
    s1_d.is_last  = last_slot;
    s1_d.sx       = st[15:0];
    s1_d.sy       = st[31:16];
    s1_d.ex       = en[15:0];
    s1_d.ey       = en[31:16];
    s1_d.lt_press = s0_time_q < press_q;
    s1_d.etime    = s0_time_q - press_q;
    s1_d.ev       = tgpg_pkg::EV_DOWN;
  end

  // Stage 2: compare against the move time and form |end - start| * t.
  always_comb begin
    logic signed [16:0] dx, dy;
    logic [15:0] ax, ay;
    s2_d         = s1_q;
    dx           = 17'(s1_q.ex) - 17'(s1_q.sx);
    dy           = 17'(s1_q.ey) - 17'(s1_q.sy);
    ax           = dx[16] ? 16'(-dx) : dx[15:0];
    ay           = dy[16] ? 16'(-dy) : dy[15:0];
    s2_d.negx    = dx[16];
    s2_d.negy    = dy[16];
    s2_d.remx    = 48'(ax) * 48'(s1_q.etime);
    s2_d.remy    = 48'(ay) * 48'(s1_q.etime);
    s2_d.lt_move = s1_q.etime < move_q;
    s2_d.etime   = s1_q.etime - move_q;
  end

  // Stage 3: settle the phase.
  always_comb begin
    s3_d = s2_q;
    priority if (s2_q.lt_press) begin
      s3_d.ev = tgpg_pkg::EV_DOWN;
    end else if (s2_q.lt_move) begin
      s3_d.ev = tgpg_pkg::EV_MOVE;
    end else if (s2_q.etime < hold_q) begin
      s3_d.ev = tgpg_pkg::EV_DOWN;
    end else begin
      s3_d.ev = tgpg_pkg::EV_UP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

  // Divider stages: quotient of the product by the move time.
  tgpg_pkg::pipe_t dv_d [NDiv];
  tgpg_pkg::pipe_t dv_q [NDiv];
  logic [NDiv-1:0] dv_valid_q;

  for (genvar g = 0; g < NDiv; g++) begin : g_div
    tgpg_div_step #(.STEP(g)) u_step (
      .d_i   ((g == 0) ? s3_q : dv_q[(g == 0) ? 0 : g - 1]),
      .den_i (move_q),
      .d_o   (dv_d[g])
    );

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[g] <= dv_d[g];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid_q <= '0;
    end else if (adv) begin
      dv_valid_q <= {dv_valid_q[NDiv-2:0], s3_valid_q};
    end
  end

  // Result stage: apply the sign and pick the position for the phase.
  tgpg_pkg::out_req_t out_d;

  always_comb begin
    tgpg_pkg::pipe_t p;
    logic signed [16:0] qx, qy;
    logic up;
    p  = dv_q[NDiv-1];
    qx = p.negx ? -$signed({1'b0, p.qx}) : $signed({1'b0, p.qx});
    qy = p.negy ? -$signed({1'b0, p.qy}) : $signed({1'b0, p.qy});
    up = (p.ev == tgpg_pkg::EV_UP);
    out_d.finger_index = p.fidx;
    if (p.ev == tgpg_pkg::EV_MOVE) begin
      out_d.pos_x = 16'(17'(p.sx) + qx);
      out_d.pos_y = 16'(17'(p.sy) + qy);
    end else if (p.lt_press) begin
      out_d.pos_x = p.sx;
      out_d.pos_y = p.sy;
    end else begin
      out_d.pos_x = p.ex;
      out_d.pos_y = p.ey;
    end
    out_d.touch_event    = p.ev;
    out_d.pressure       = up ? 8'd0 : tgpg_pkg::TouchPressure;
    out_d.position_valid = !up;
    out_d.gesture_done   = up;
    out_d.last           = p.is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_valid_q[NDiv-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// ===== rtl/tgpg_checker.sv =====
// ----------------------------------------------------------------------------
// Touch gesture point generator checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module tgpg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input tgpg_pkg::out_req_t            out_req_o
);

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed");

  // Finger 1 is always the final result of a request.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_req_o.last |-> !out_req_o.finger_index)
    else $error("non-final result for finger 1");

  // Pressure and position flag follow the phase.
  a_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.position_valid ==
                     (out_req_o.touch_event != tgpg_pkg::EV_UP)) &&
                    (out_req_o.pressure ==
                     (out_req_o.position_valid ? tgpg_pkg::TouchPressure : 8'd0)))
    else $error("pressure or position flag inconsistent with phase");

  // Shared phase lengths: done matches this finger being up.
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_req_o.gesture_done ==
                    (out_req_o.touch_event == tgpg_pkg::EV_UP))
    else $error("done flag inconsistent");

endmodule

bind touch_gesture_point_generator tgpg_checker u_tgpg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);

// ===== tb/touch_gesture_point_generator_checker.sv =====
// ----------------------------------------------------------------------------
// Touch gesture point checker
// Watches the configuration port and both request channels of the gesture
// point generator. It predicts the touch points of every accepted request
// and compares them with the results as they leave the block.
// ----------------------------------------------------------------------------
module touch_gesture_point_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  tgpg_pkg::in_req_t             in_req_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  tgpg_pkg::out_req_t            out_req_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [tgpg_pkg::AddrBits-1:0] paddr_i,
  input  logic [31:0]                   pwdata_i,
  output int                            pending_o,
  output int                            fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] start_pt [2];
  logic [31:0] end_pt [2];
  logic [31:0] press_len, move_len, hold_len;
  logic [1:0]  count_reg;
  tgpg_pkg::out_req_t points_q [$];

  assign pending_o = points_q.size();

  function automatic logic [15:0] interp(logic signed [15:0] a, logic signed [15:0] b,
                                         logic [31:0] t, logic [31:0] dur);
    longint num;
    num = (longint'(b) - longint'(a)) * longint'(t);
    return 16'(num / longint'(dur) + longint'(a));
  endfunction

  task automatic queue_points(tgpg_pkg::in_req_t r);
    logic [31:0] elapsed, e;
    int          n, ups;
    tgpg_pkg::out_req_t pt [2];
    logic signed [15:0] x1, y1, x2, y2;
    elapsed = r.now_ms - r.start_ms;
    n = (count_reg == 0) ? 1 : (count_reg > 2 ? 2 : int'(count_reg));
    ups = 0;
    for (int i = 0; i < n; i++) begin
      x1 = start_pt[i][15:0];
      y1 = start_pt[i][31:16];
      x2 = end_pt[i][15:0];
      y2 = end_pt[i][31:16];
      pt[i] = '0;
      pt[i].finger_index = i[0];
      e = elapsed;
      if (e < press_len) begin
        pt[i].pos_x = x1;
        pt[i].pos_y = y1;
        pt[i].touch_event = tgpg_pkg::EV_DOWN;
      end else begin
        e = e - press_len;
        if (e < move_len) begin
          pt[i].pos_x = interp(x1, x2, e, move_len);
          pt[i].pos_y = interp(y1, y2, e, move_len);
          pt[i].touch_event = tgpg_pkg::EV_MOVE;
        end else begin
          e = e - move_len;
          pt[i].pos_x = x2;
          pt[i].pos_y = y2;
          pt[i].touch_event = (e < hold_len) ? tgpg_pkg::EV_DOWN : tgpg_pkg::EV_UP;
        end
      end
      if (pt[i].touch_event == tgpg_pkg::EV_UP) begin
        ups++;
      end else begin
        pt[i].pressure = tgpg_pkg::TouchPressure;
        pt[i].position_valid = 1'b1;
      end
    end
    for (int i = 0; i < n; i++) begin
      pt[i].gesture_done = (ups == n);
      pt[i].last = (i + 1 == n);
      points_q.push_back(pt[i]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tgpg_pkg::out_req_t want;
    if (!rst_ni) begin
      start_pt[0] <= '0;
      start_pt[1] <= '0;
      end_pt[0] <= '0;
      end_pt[1] <= '0;
      press_len <= 32'd50;
      move_len <= '0;
      hold_len <= 32'd5;
      count_reg <= 2'd1;
      fail_count_o <= 0;
      points_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        unique case (tgpg_pkg::reg_idx_e'(paddr_i[4:2]))
          tgpg_pkg::REG_F0_START: start_pt[0] <= pwdata_i;
          tgpg_pkg::REG_F0_END:   end_pt[0] <= pwdata_i;
          tgpg_pkg::REG_F1_START: start_pt[1] <= pwdata_i;
          tgpg_pkg::REG_F1_END:   end_pt[1] <= pwdata_i;
          tgpg_pkg::REG_PRESS:    press_len <= pwdata_i;
          tgpg_pkg::REG_MOVE:     move_len <= pwdata_i;
          tgpg_pkg::REG_HOLD:     hold_len <= pwdata_i;
          tgpg_pkg::REG_COUNT:    count_reg <= pwdata_i[1:0];
        endcase
      end
      // Results are checked before this edge's request is predicted, so a
      // request and its own result can never meet in the same cycle anyway.
      if (out_valid_i && !out_stall_i) begin
        if (points_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_req_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = points_q.pop_front();
          if (out_req_i !== want) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, out_req_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        queue_points(in_req_i);
      end
    end
  end

endmodule

// ===== tb/touch_gesture_point_generator_tb.sv =====
// ----------------------------------------------------------------------------
// Touch gesture point generator testbench
// Drives time samples and register settings into the generator under several
// idle and stall patterns; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module touch_gesture_point_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 600000;
  localparam int Drain = 30;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  tgpg_pkg::in_req_t             in_req_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  tgpg_pkg::out_req_t            out_req_o;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [tgpg_pkg::AddrBits-1:0] paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  int pending, fail_count;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 1'b0;

  // Our own view of the phase lengths, used only to aim samples at phases.
  logic [31:0] press_len = 32'd50, move_len = '0, hold_len = 32'd5;

  always #4 clk_i = ~clk_i;

  touch_gesture_point_generator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_req_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  touch_gesture_point_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_req_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_req_i(out_req_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata), .pending_o(pending), .fail_count_o(fail_count)
  );

  // The receiver stalls at random, or solidly while a long hold-off runs.
  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("touch_gesture_point_generator_tb: FAIL");
      $finish;
    end
  end

  // One APB write: a setup phase, an access phase, then an idle phase.
  task automatic write_reg(tgpg_pkg::reg_idx_e idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= tgpg_pkg::AddrBits'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    case (idx)
      tgpg_pkg::REG_PRESS: press_len = value;
      tgpg_pkg::REG_MOVE:  move_len = value;
      tgpg_pkg::REG_HOLD:  hold_len = value;
      default: ;
    endcase
  endtask

  // Takes the request away, waits until every predicted point has come
  // out, then lets the pipeline settle so that a register write never
  // lands on work in flight.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  // Offers one request, with a random gap first, and holds it until taken.
  task automatic send(logic [31:0] now, logic [31:0] start);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_req_i <= '{now_ms: now, start_ms: start};
    @(posedge clk_i iff (in_valid_i && !in_stall_o));
  endtask

  // Sends a sample whose elapsed time is e, from a random start tick.
  task automatic send_elapsed(longint e);
    logic [31:0] start;
    start = $urandom;
    send(start + 32'(e), start);
  endtask

  // Elapsed time aimed at a phase, a phase edge, or anywhere at all.
  function automatic longint pick_elapsed();
    longint p, m, h;
    p = press_len;
    m = move_len;
    h = hold_len;
    case ($urandom_range(9))
      0: return $urandom;
      1: return (p == 0) ? 0 : $urandom_range(0, 32'(p - 1));
      2: return p - 1;
      3: return p;
      4: return p + ((m == 0) ? 0 : longint'($urandom_range(0, 32'(m - 1))));
      5: return p + m - 1;
      6: return p + m;
      7: return p + m + h - 1;
      8: return p + m + h;
      default: return p + m + h + $urandom_range(0, 1000);
    endcase
  endfunction

  function automatic logic [31:0] pick_point();
    case ($urandom_range(5))
      0: return 32'h8000_8000;
      1: return 32'h7fff_7fff;
      2: return {16'(int'($urandom_range(0, 800))), 16'(int'($urandom_range(0, 480)))};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_len();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return $urandom;
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  task automatic random_config();
    write_reg(tgpg_pkg::REG_F0_START, pick_point());
    write_reg(tgpg_pkg::REG_F0_END, pick_point());
    write_reg(tgpg_pkg::REG_F1_START, pick_point());
    write_reg(tgpg_pkg::REG_F1_END, pick_point());
    write_reg(tgpg_pkg::REG_PRESS, pick_len());
    write_reg(tgpg_pkg::REG_MOVE, pick_len());
    write_reg(tgpg_pkg::REG_HOLD, pick_len());
    write_reg(tgpg_pkg::REG_COUNT, 32'($urandom_range(0, 3)));
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Reset settings first: press, hold edge, up, and a
    // start tick ahead of the current one so the difference wraps.
    send(32'd0, 32'd0);
    send(32'd49, 32'd0);
    send(32'd50, 32'd0);
    send(32'd54, 32'd0);
    send(32'd55, 32'd0);
    send(32'd10, 32'hffff_fff0);
    send(32'hffff_ffff, 32'hffff_ffff);
    wait_idle();

    // Two fingers moving across the full coordinate range in both
    // directions, so the interpolation truncates toward zero either way.
    write_reg(tgpg_pkg::REG_F0_START, 32'h8000_8000);
    write_reg(tgpg_pkg::REG_F0_END, 32'h7fff_7fff);
    write_reg(tgpg_pkg::REG_F1_START, 32'h7fff_0000);
    write_reg(tgpg_pkg::REG_F1_END, 32'h8001_ffff);
    write_reg(tgpg_pkg::REG_PRESS, 32'd10);
    write_reg(tgpg_pkg::REG_MOVE, 32'd7);
    write_reg(tgpg_pkg::REG_HOLD, 32'd3);
    write_reg(tgpg_pkg::REG_COUNT, 32'd2);
    for (int e = 8; e <= 21; e++) send_elapsed(e);
    wait_idle();

    // Out-of-range finger counts, then the largest phase lengths, then all
    // lengths zero so the gesture is over at once.
    write_reg(tgpg_pkg::REG_COUNT, 32'd0);
    send_elapsed(12);
    wait_idle();
    write_reg(tgpg_pkg::REG_COUNT, 32'd3);
    write_reg(tgpg_pkg::REG_PRESS, 32'hffff_ffff);
    write_reg(tgpg_pkg::REG_MOVE, 32'hffff_ffff);
    send_elapsed(32'hffff_fffe);
    send_elapsed(32'hffff_ffff);
    wait_idle();
    write_reg(tgpg_pkg::REG_PRESS, 32'd0);
    write_reg(tgpg_pkg::REG_MOVE, 32'd0);
    write_reg(tgpg_pkg::REG_HOLD, 32'd0);
    send_elapsed(0);
    wait_idle();

    // Random part: six settings, each under one idle pattern.
    for (int ph = 0; ph < 6; ph++) begin
      random_config();
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 72; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      fork
        begin
          for (int k = 0; k < 120; k++) begin
            send_elapsed(pick_elapsed());
            // In the fourth setting only, the sender once waits for the block to drain completely.
            if (ph == 3 && k == 60) begin
              in_valid_i <= 1'b0;
              @(posedge clk_i);
              while (pending != 0) @(posedge clk_i);
            end
          end
          in_valid_i <= 1'b0;
          @(posedge clk_i);
        end
        // A long receiver hold-off while the sender keeps offering samples,
        // so the pipeline fills and backs up into the input.
        if (ph == 0) begin
          repeat (40) @(posedge clk_i);
          hold_off = 1'b1;
          repeat (300) @(posedge clk_i);
          hold_off = 1'b0;
        end
      join
      stall_pct = 0;
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("touch_gesture_point_generator_tb: PASS");
    end else begin
      $display("touch_gesture_point_generator_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tgpg_pkg.sv
rtl/tgpg_div_step.sv
rtl/touch_gesture_point_generator.sv
rtl/tgpg_checker.sv
tb/touch_gesture_point_generator_checker.sv
tb/touch_gesture_point_generator_tb.sv
